/* src/lfdc_pkg.sv */
// lfdc_pkg: shared types and constants of the line follower drive controller
// holds the command format passed from the decode front end to the slot generator
// no dependencies

package lfdc_pkg;

    localparam logic [3:0] MAX_TICKS = 4'd10;

    localparam logic [3:0] PAT_ALL        = 4'b1111;
    localparam logic [3:0] PAT_CENTRE     = 4'b0110;
    localparam logic [3:0] PAT_SL         = 4'b0100;
    localparam logic [3:0] PAT_SR         = 4'b0010;
    localparam logic [3:0] PAT_NONE       = 4'b0000;
    localparam logic [3:0] PAT_LEFT_OUT   = 4'b1000;
    localparam logic [3:0] PAT_LEFT_MID   = 4'b1100;
    localparam logic [3:0] PAT_LEFT_WIDE  = 4'b1110;
    localparam logic [3:0] PAT_RIGHT_OUT  = 4'b0001;
    localparam logic [3:0] PAT_RIGHT_MID  = 4'b0011;
    localparam logic [3:0] PAT_RIGHT_WIDE = 4'b0111;

    typedef enum logic [1:0] {
        CFG_FRAME_TICKS = 2'd0,
        CFG_FULL_ON     = 2'd1,
        CFG_MILD_ON     = 2'd2,
        CFG_RECOVER_ON  = 2'd3
    } cfg_index_t;

    typedef enum logic [3:0] {
        MODE_WAIT  = 4'b0001,
        MODE_RUN   = 4'b0010,
        MODE_PIV_L = 4'b0100,
        MODE_PIV_R = 4'b1000
    } mode_t;

    typedef enum logic [2:0] {
        DIR_NONE = 3'd0,
        DIR_PL   = 3'd1,
        DIR_PR   = 3'd2,
        DIR_SL   = 3'd3,
        DIR_SR   = 3'd4
    } dir_t;

    typedef enum logic [1:0] {
        CMD_ZERO       = 2'd0,
        CMD_WAIT       = 2'd1,
        CMD_FRAME      = 2'd2,
        CMD_FRAME_WAIT = 2'd3
    } cmd_kind_t;

    typedef enum logic [1:0] {
        SLOT_TICK = 2'd0,
        SLOT_WAIT = 2'd1,
        SLOT_ZERO = 2'd2
    } slot_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [3:0] lon;
        logic [3:0] ron;
        logic [3:0] flen;
    } cmd_t;

    localparam int CMD_W = $bits(cmd_t);

endpackage

/* src/line_follower_drive_controller.sv */
// line_follower_drive_controller: top level of the line follower drive controller
// front end decode, command queue and slot generator; depends on lfdc_pkg and submodules
//
//   channel   direction  handshake          payload
//   s_        in         s_tvalid/s_tready  s_tdata: sensor_raw, start_button
//   m_        out        m_tvalid/m_tready  m_tdata: motor levels; m_tuser: slot kind; m_tlast
//   cfg_      in         cfg_we             cfg_index, cfg_wdata
//
// one result per cycle from the slot generator while the m_ side does not stall it; an item
// causes 1 to 11 results, the next command is loaded with the last result
// a sample is taken in the cycle it arrives while the command queue has room
// reset clears modes, direction, motor levels, queue and output valid flag
// a stalled m_ side fills the queue, then s_tready drops

module line_follower_drive_controller #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [3:0] sensor_raw, [4] start_button
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [0] motor_left, [1] motor_right
    output logic [1:0] m_tuser,    // [1:0] slot_kind
    output logic       m_tlast,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [3:0] cfg_wdata
);

    lfdc_pkg::cmd_t front_cmd, queue_cmd;
    logic           q_push, q_full, q_pop, q_empty;
    logic           motor_left, motor_right;
    logic [1:0]     slot_kind;

    lfdc_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .sensor_raw   (s_tdata[3:0]),
        .start_button (s_tdata[4]),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_cmd        (front_cmd)
    );

    lfdc_cmd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (front_cmd),
        .full    (q_full),
        .pop     (q_pop),
        .dout    (queue_cmd),
        .empty   (q_empty)
    );

    lfdc_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_empty     (q_empty),
        .q_cmd       (queue_cmd),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .motor_left  (motor_left),
        .motor_right (motor_right),
        .slot_kind   (slot_kind),
        .last_of_run (m_tlast)
    );

    assign m_tdata = {6'b000000, motor_right, motor_left};
    assign m_tuser = slot_kind;

    a_kind_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (slot_kind != 2'd3))
        else $error("illegal slot kind on output");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    a_item_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !q_empty)
        else $error("accepted sample lost before queue");

    a_out_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                     && $stable(m_tlast)))
        else $error("output changed while stalled");

endmodule

/* src/lfdc_front.sv */
// lfdc_front: accepts sensor samples, keeps run and pivot state, decodes commands
// holds the configuration registers; depends on lfdc_pkg

module lfdc_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [3:0]         sensor_raw,
    input  logic               start_button,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [3:0]         cfg_wdata,
    input  logic               q_full,
    output logic               q_push,
    output lfdc_pkg::cmd_t     q_cmd
);

    logic [3:0]      frame_ticks_reg, full_on_reg, mild_on_reg, recover_on_reg;
    lfdc_pkg::mode_t mode_reg, mode_next;
    logic            seen_high_reg, seen_high_next;
    logic [3:0]      line_prev_reg, line_prev_next;
    logic [3:0]      pivot_prev_reg, pivot_prev_next;
    lfdc_pkg::dir_t  dir_reg, dir_next;
    logic [3:0]      sens, pat, flen;
    logic            accept;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign q_push   = accept;
    assign sens     = ~sensor_raw;
    assign flen     = (frame_ticks_reg > lfdc_pkg::MAX_TICKS) ? lfdc_pkg::MAX_TICKS
                                                                : frame_ticks_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_ticks_reg <= 4'd10;
            full_on_reg     <= 4'd10;
            mild_on_reg     <= 4'd7;
            recover_on_reg  <= 4'd4;
        end else if (cfg_we) begin
            case (lfdc_pkg::cfg_index_t'(cfg_index))
                lfdc_pkg::CFG_FRAME_TICKS: frame_ticks_reg <= cfg_wdata;
                lfdc_pkg::CFG_FULL_ON:     full_on_reg     <= cfg_wdata;
                lfdc_pkg::CFG_MILD_ON:     mild_on_reg     <= cfg_wdata;
                lfdc_pkg::CFG_RECOVER_ON:  recover_on_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        mode_next       = mode_reg;
        seen_high_next  = seen_high_reg;
        line_prev_next  = line_prev_reg;
        pivot_prev_next = pivot_prev_reg;
        dir_next        = dir_reg;
        pat             = 4'd0;
        q_cmd.kind      = lfdc_pkg::CMD_ZERO;
        q_cmd.lon       = full_on_reg;
        q_cmd.ron       = full_on_reg;
        q_cmd.flen      = flen;
        case (mode_reg)
            lfdc_pkg::MODE_WAIT: begin
                if (!start_button && seen_high_reg) begin
                    mode_next = lfdc_pkg::MODE_RUN;
                end
                seen_high_next = start_button;
            end
            lfdc_pkg::MODE_RUN: begin
                pat            = sens & line_prev_reg;
                line_prev_next = sens;
                case (pat) inside
                    lfdc_pkg::PAT_CENTRE: begin
                        q_cmd.kind = lfdc_pkg::CMD_FRAME;
                    end
                    lfdc_pkg::PAT_LEFT_OUT, lfdc_pkg::PAT_LEFT_MID,
                    lfdc_pkg::PAT_LEFT_WIDE: begin
                        mode_next       = lfdc_pkg::MODE_PIV_L;
                        dir_next        = lfdc_pkg::DIR_PL;
                        pivot_prev_next = 4'd0;
                    end
                    lfdc_pkg::PAT_RIGHT_OUT, lfdc_pkg::PAT_RIGHT_MID,
                    lfdc_pkg::PAT_RIGHT_WIDE: begin
                        mode_next       = lfdc_pkg::MODE_PIV_R;
                        dir_next        = lfdc_pkg::DIR_PR;
                        pivot_prev_next = 4'd0;
                    end
                    lfdc_pkg::PAT_SL: begin
                        q_cmd.kind = lfdc_pkg::CMD_FRAME;
                        q_cmd.lon  = mild_on_reg;
                        dir_next   = lfdc_pkg::DIR_SL;
                    end
                    lfdc_pkg::PAT_SR: begin
                        q_cmd.kind = lfdc_pkg::CMD_FRAME;
                        q_cmd.ron  = mild_on_reg;
                        dir_next   = lfdc_pkg::DIR_SR;
                    end
                    lfdc_pkg::PAT_NONE: begin
                        q_cmd.kind = lfdc_pkg::CMD_FRAME;
                        if (dir_reg == lfdc_pkg::DIR_SL) begin
                            q_cmd.lon = recover_on_reg;
                        end else if (dir_reg == lfdc_pkg::DIR_SR) begin
                            q_cmd.ron = recover_on_reg;
                        end
                    end
                    lfdc_pkg::PAT_ALL: begin
                        q_cmd.kind = (dir_reg == lfdc_pkg::DIR_NONE) ?
                                     lfdc_pkg::CMD_FRAME_WAIT : lfdc_pkg::CMD_WAIT;
                    end
                    default: begin
                        q_cmd.kind = lfdc_pkg::CMD_WAIT;
                    end
                endcase
            end
            default: begin
                pat             = sens & pivot_prev_reg;
                pivot_prev_next = sens;
                if (pat inside {lfdc_pkg::PAT_SL, lfdc_pkg::PAT_SR, lfdc_pkg::PAT_CENTRE})
                begin
                    mode_next = lfdc_pkg::MODE_RUN;
                end else if (mode_reg == lfdc_pkg::MODE_PIV_L) begin
                    q_cmd.kind = lfdc_pkg::CMD_FRAME;
                    q_cmd.lon  = 4'd0;
                end else begin
                    q_cmd.kind = lfdc_pkg::CMD_FRAME;
                    q_cmd.ron  = 4'd0;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= lfdc_pkg::MODE_WAIT;
            seen_high_reg  <= 1'b0;
            line_prev_reg  <= 4'd0;
            pivot_prev_reg <= 4'd0;
            dir_reg        <= lfdc_pkg::DIR_NONE;
        end else if (accept) begin
            mode_reg       <= mode_next;
            seen_high_reg  <= seen_high_next;
            line_prev_reg  <= line_prev_next;
            pivot_prev_reg <= pivot_prev_next;
            dir_reg        <= dir_next;
        end
    end

endmodule

/* src/lfdc_cmd_fifo.sv */
// lfdc_cmd_fifo: short register queue of decoded commands
// sits between front end and slot generator; depends on lfdc_pkg

module lfdc_cmd_fifo #(
    parameter int DEPTH = 2
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  lfdc_pkg::cmd_t  din,
    output logic            full,
    input  logic            pop,
    output lfdc_pkg::cmd_t  dout,
    output logic            empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lfdc_pkg::cmd_t   mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* src/lfdc_back.sv */
// lfdc_back: turns commands into pwm tick, wait and zero-time slots
// keeps the motor levels and the output register; depends on lfdc_pkg

module lfdc_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_empty,
    input  lfdc_pkg::cmd_t  q_cmd,
    output logic            q_pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic            motor_left,
    output logic            motor_right,
    output logic [1:0]      slot_kind,
    output logic            last_of_run
);

    lfdc_pkg::cmd_t cmd_reg;
    logic           busy_reg, busy_next;
    logic [3:0]     cnt_reg, cnt_next;
    logic           tail_reg, tail_next;
    logic           left_reg, right_reg;
    logic           m_valid_reg;
    logic           out_left_reg, out_right_reg, out_last_reg;
    logic [1:0]     out_kind_reg;
    logic           emit, load;
    logic           res_left, res_right, res_last;
    lfdc_pkg::slot_kind_t res_kind;
    logic           has_tail, last_tick;

    assign emit      = busy_reg && (!m_valid_reg || m_tready);
    assign has_tail  = (cmd_reg.kind == lfdc_pkg::CMD_FRAME_WAIT);
    assign last_tick = (cnt_reg == 4'(cmd_reg.flen - 4'd1));

    always_comb begin
        res_left  = left_reg;
        res_right = right_reg;
        res_kind  = lfdc_pkg::SLOT_ZERO;
        res_last  = 1'b1;
        cnt_next  = cnt_reg;
        tail_next = tail_reg;
        if (tail_reg) begin
            res_kind = lfdc_pkg::SLOT_WAIT;
        end else begin
            case (cmd_reg.kind)
                lfdc_pkg::CMD_ZERO: res_kind = lfdc_pkg::SLOT_ZERO;
                lfdc_pkg::CMD_WAIT: res_kind = lfdc_pkg::SLOT_WAIT;
                default: begin
                    if (cmd_reg.flen == 4'd0) begin
                        if (cmd_reg.lon != 4'd0) res_left = 1'b1;
                        if (cmd_reg.ron != 4'd0) res_right = 1'b1;
                        res_kind  = lfdc_pkg::SLOT_ZERO;
                        res_last  = !has_tail;
                        tail_next = has_tail;
                    end else begin
                        res_left  = (cnt_reg < cmd_reg.lon);
                        res_right = (cnt_reg < cmd_reg.ron);
                        res_kind  = lfdc_pkg::SLOT_TICK;
                        res_last  = last_tick && !has_tail;
                        cnt_next  = cnt_reg + 4'd1;
                        tail_next = last_tick && has_tail;
                    end
                end
            endcase
        end
    end

    assign load  = (!busy_reg || (emit && res_last)) && !q_empty;
    assign q_pop = load;

    always_comb begin
        busy_next = busy_reg;
        if (load) begin
            busy_next = 1'b1;
        end else if (emit && res_last) begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            cmd_reg <= q_cmd;
        end
        if (load) begin
            cnt_reg <= 4'd0;
        end else if (emit) begin
            cnt_reg <= cnt_next;
        end
        if (emit) begin
            out_left_reg  <= res_left;
            out_right_reg <= res_right;
            out_kind_reg  <= res_kind;
            out_last_reg  <= res_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            tail_reg    <= 1'b0;
            left_reg    <= 1'b0;
            right_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            if (load) begin
                tail_reg <= 1'b0;
            end else if (emit) begin
                tail_reg <= tail_next;
            end
            if (emit) begin
                left_reg  <= res_left;
                right_reg <= res_right;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid    = m_valid_reg;
    assign motor_left  = out_left_reg;
    assign motor_right = out_right_reg;
    assign slot_kind   = out_kind_reg;
    assign last_of_run = out_last_reg;

endmodule
